// File: rtl/mfw_pkg.sv
// mfw_pkg: shared widths, constants, register codes and types for the
// mitchell filter weight unit; used by every module under rtl/
package mfw_pkg;

    // offset fraction bits and the shift that brings 2*|off|*inv_r to Q16
    localparam int FRAC_BITS = 12;
    localparam int TQ_SHIFT  = FRAC_BITS - 2;

    // port widths
    localparam int OFF_W  = 16;
    localparam int CFG_W  = 16;
    localparam int IDX_W  = 3;
    localparam int WOUT_W = 24;

    // lane datapath widths
    localparam int MAG_W  = OFF_W + 1;
    localparam int PROD_W = MAG_W + CFG_W;
    localparam int RAW_W  = PROD_W + 1;
    localparam int TQ_W   = 18;
    localparam int SQ_W   = 2 * TQ_W;
    localparam int T2_W   = 19;
    localparam int CUBE_W = T2_W + TQ_W;
    localparam int T3_W   = 20;
    localparam int K_W    = 23;
    localparam int SUM_W  = 44;
    localparam int QSHIFT = 9;
    localparam int Q_W    = 35;
    localparam int U_W    = Q_W + 1;
    localparam int HALF_W = U_W / 2;
    localparam int S3_W   = HALF_W + 1;
    localparam int HM_W   = 35;
    localparam int RCP_W  = 20;
    localparam int SM_W   = S3_W + RCP_W;
    localparam int QT_W   = 18;
    localparam int AW_W   = 32;
    localparam int WP_W   = 2 * AW_W;

    // pipeline depth
    localparam int LANE_STAGES  = 14;
    localparam int MERGE_STAGES = 2;
    localparam int PIPE_STAGES  = LANE_STAGES + MERGE_STAGES;

    // fixed-point constants
    localparam int ONE_Q14 = 16384;
    localparam logic [RAW_W-1:0] TQ_HALF  = RAW_W'(1) << (TQ_SHIFT - 1);
    localparam logic [RAW_W-1:0] ONE_Q16  = RAW_W'(65536);
    localparam logic [RAW_W-1:0] TWO_Q16  = RAW_W'(131072);
    localparam logic [SQ_W-1:0]  SQ_HALF  = SQ_W'(32768);
    localparam logic [CUBE_W-1:0] CUBE_HALF = CUBE_W'(32768);
    localparam logic signed [SUM_W-1:0] SIXTH_HALF = SUM_W'(768);

    // floor division by three: u = hi*2^18 + lo, with 2^18 - 1 divisible by 3
    localparam logic [U_W-1:0]   U_BIAS       = U_W'(3) << (U_W - 2);
    localparam logic [U_W-1:0]   U_BIAS_THIRD = U_W'(1) << (U_W - 2);
    localparam int               DIV3_SHIFT   = 21;
    localparam logic [16:0]      DIV3_HI_MULT = 17'(((2 ** HALF_W) - 1) / 3);
    localparam logic [RCP_W-1:0] DIV3_RECIP   = RCP_W'(((2 ** DIV3_SHIFT) + 2) / 3);

    // final rounding and saturation
    localparam int WSHIFT = 22;
    localparam logic signed [WP_W-1:0] W_ROUND = WP_W'(1) <<< (WSHIFT - 1);
    localparam logic signed [WP_W-1:0] W_MAX   = WP_W'(8388607);
    localparam logic signed [WP_W-1:0] W_MIN   = -WP_W'(8388608);

    // register codes
    localparam logic [IDX_W-1:0] CFG_BLUR_B       = IDX_W'(0);
    localparam logic [IDX_W-1:0] CFG_RING_C       = IDX_W'(1);
    localparam logic [IDX_W-1:0] CFG_INV_RADIUS_X = IDX_W'(2);
    localparam logic [IDX_W-1:0] CFG_INV_RADIUS_Y = IDX_W'(3);

    // register reset values
    localparam logic signed [CFG_W-1:0] BLUR_B_RESET     = CFG_W'(5461);
    localparam logic signed [CFG_W-1:0] RING_C_RESET     = CFG_W'(5461);
    localparam logic [CFG_W-1:0]        INV_RADIUS_RESET = CFG_W'(8192);

    // cubic coefficients, Q14, inner (t <= 1) and outer (1 < t <= 2)
    typedef struct packed {
        logic signed [K_W-1:0] in_k3;
        logic signed [K_W-1:0] in_k2;
        logic signed [K_W-1:0] in_k0;
        logic signed [K_W-1:0] out_k3;
        logic signed [K_W-1:0] out_k2;
        logic signed [K_W-1:0] out_k1;
        logic signed [K_W-1:0] out_k0;
    } mfw_coef_t;

    // per-stage advance enables
    typedef struct packed {
        logic [LANE_STAGES-1:0]  lane;
        logic [MERGE_STAGES-1:0] merge;
    } mfw_adv_t;

endpackage

// File: rtl/mfw_coef.sv
// mfw_coef: builds the inner and outer cubic coefficients from B and C
// depends on mfw_pkg
module mfw_coef (
    input  logic                              clk,
    input  logic signed [mfw_pkg::CFG_W-1:0]  blur_b,
    input  logic signed [mfw_pkg::CFG_W-1:0]  ring_c,
    output mfw_pkg::mfw_coef_t                coef
);

    logic signed [mfw_pkg::K_W-1:0] b;
    logic signed [mfw_pkg::K_W-1:0] c;
    mfw_pkg::mfw_coef_t coef_next;
    mfw_pkg::mfw_coef_t coef_reg;

    // integer combinations of b and c
    always_comb
    begin
        b = mfw_pkg::K_W'(blur_b);
        c = mfw_pkg::K_W'(ring_c);
        coef_next.in_k3  = mfw_pkg::K_W'(12 * mfw_pkg::ONE_Q14)
                           - b * mfw_pkg::K_W'(9) - c * mfw_pkg::K_W'(6);
        coef_next.in_k2  = mfw_pkg::K_W'(-18 * mfw_pkg::ONE_Q14)
                           + b * mfw_pkg::K_W'(12) + c * mfw_pkg::K_W'(6);
        coef_next.in_k0  = mfw_pkg::K_W'(6 * mfw_pkg::ONE_Q14) - b * mfw_pkg::K_W'(2);
        coef_next.out_k3 = -b - c * mfw_pkg::K_W'(6);
        coef_next.out_k2 = b * mfw_pkg::K_W'(6) + c * mfw_pkg::K_W'(30);
        coef_next.out_k1 = -(b * mfw_pkg::K_W'(12)) - c * mfw_pkg::K_W'(48);
        coef_next.out_k0 = b * mfw_pkg::K_W'(8) + c * mfw_pkg::K_W'(24);
    end

    // registered; follows the B and C registers after a write
    always_ff @(posedge clk)
    begin
        coef_reg <= coef_next;
    end

    assign coef = coef_reg;

endmodule

// File: rtl/mfw_axis_lane.sv
// mfw_axis_lane: one axis of the filter, offset to Q22 axis weight
// depends on mfw_pkg; coefficients come from mfw_coef
module mfw_axis_lane (
    input  logic                              clk,
    input  mfw_pkg::mfw_adv_t                 adv,
    input  logic signed [mfw_pkg::OFF_W-1:0]  offset,
    input  logic [mfw_pkg::CFG_W-1:0]         inv_radius,
    input  mfw_pkg::mfw_coef_t                coef,
    output logic signed [mfw_pkg::AW_W-1:0]   axis_weight
);

    // stage registers
    logic [mfw_pkg::MAG_W-1:0]  mag_reg;
    logic [mfw_pkg::PROD_W-1:0] prod_reg;
    logic [mfw_pkg::TQ_W-1:0]   tq2_reg, tq3_reg, tq4_reg, tq5_reg, tq6_reg;
    logic [mfw_pkg::SQ_W-1:0]   sq_reg;
    logic [mfw_pkg::T2_W-1:0]   t2_4_reg, t2_5_reg, t2_6_reg;
    logic [mfw_pkg::CUBE_W-1:0] cube_reg;
    logic [mfw_pkg::T3_W-1:0]   t3_reg;
    logic signed [mfw_pkg::SUM_W-1:0] p3_reg, p2_reg, p1_reg, k0s_reg;
    logic signed [mfw_pkg::SUM_W-1:0] sa_reg, sb_reg;
    logic signed [mfw_pkg::Q_W-1:0]   q_reg;
    logic [mfw_pkg::U_W-1:0]          u_reg;
    logic [mfw_pkg::HM_W-1:0]         hm11_reg, hm12_reg;
    logic [mfw_pkg::S3_W-1:0]         s3_reg;
    logic [mfw_pkg::SM_W-1:0]         sm_reg;
    logic signed [mfw_pkg::AW_W-1:0]  aw_reg;
    logic [mfw_pkg::LANE_STAGES-1:3]  far_reg;
    logic [7:3]                       outer_reg;

    // next values
    logic [mfw_pkg::OFF_W:0]    off_ext;
    logic [mfw_pkg::MAG_W-1:0]  mag_next;
    logic [mfw_pkg::RAW_W-1:0]  raw;
    logic [mfw_pkg::RAW_W-1:0]  tq_full;
    logic [mfw_pkg::SQ_W-1:0]   t2_full;
    logic [mfw_pkg::CUBE_W-1:0] t3_full;
    logic signed [mfw_pkg::K_W-1:0] k3_sel, k2_sel, k1_sel, k0_sel;
    logic signed [mfw_pkg::T3_W:0]  t3_s;
    logic signed [mfw_pkg::T2_W:0]  t2_s;
    logic signed [mfw_pkg::TQ_W:0]  t1_s;
    logic signed [mfw_pkg::SUM_W-1:0] p3_next, p2_next, p1_next, sum_full;
    logic [mfw_pkg::U_W-1:0]          u_next;
    logic [mfw_pkg::HALF_W-1:0]       u_hi, u_lo;
    logic [mfw_pkg::QT_W-1:0]         quot;
    logic [mfw_pkg::U_W-1:0]          w_full;

    // magnitude of the offset
    always_comb
    begin
        off_ext  = {offset[mfw_pkg::OFF_W-1], offset};
        mag_next = offset[mfw_pkg::OFF_W-1] ? (~off_ext + 1'b1) : off_ext;
    end

    always_ff @(posedge clk)
    begin
        if (adv.lane[0])
        begin
            mag_reg <= mag_next;
        end
    end

    // scale by inverse radius
    always_ff @(posedge clk)
    begin
        if (adv.lane[1])
        begin
            prod_reg <= mfw_pkg::PROD_W'(mag_reg) * mfw_pkg::PROD_W'(inv_radius);
        end
    end

    // double, round to Q16, classify the interval
    always_comb
    begin
        raw     = {prod_reg, 1'b0};
        tq_full = (raw + mfw_pkg::TQ_HALF) >> mfw_pkg::TQ_SHIFT;
    end

    always_ff @(posedge clk)
    begin
        if (adv.lane[2])
        begin
            tq2_reg      <= tq_full[mfw_pkg::TQ_W-1:0];
            far_reg[3]   <= tq_full > mfw_pkg::TWO_Q16;
            outer_reg[3] <= tq_full > mfw_pkg::ONE_Q16;
        end
    end

    // t squared
    always_ff @(posedge clk)
    begin
        if (adv.lane[3])
        begin
            sq_reg       <= mfw_pkg::SQ_W'(tq2_reg) * mfw_pkg::SQ_W'(tq2_reg);
            tq3_reg      <= tq2_reg;
            far_reg[4]   <= far_reg[3];
            outer_reg[4] <= outer_reg[3];
        end
    end

    // round t2
    always_comb
    begin
        t2_full = (sq_reg + mfw_pkg::SQ_HALF) >> 16;
    end

    always_ff @(posedge clk)
    begin
        if (adv.lane[4])
        begin
            t2_4_reg     <= t2_full[mfw_pkg::T2_W-1:0];
            tq4_reg      <= tq3_reg;
            far_reg[5]   <= far_reg[4];
            outer_reg[5] <= outer_reg[4];
        end
    end

    // t2 times t
    always_ff @(posedge clk)
    begin
        if (adv.lane[5])
        begin
            cube_reg     <= mfw_pkg::CUBE_W'(t2_4_reg) * mfw_pkg::CUBE_W'(tq4_reg);
            t2_5_reg     <= t2_4_reg;
            tq5_reg      <= tq4_reg;
            far_reg[6]   <= far_reg[5];
            outer_reg[6] <= outer_reg[5];
        end
    end

    // round t3
    always_comb
    begin
        t3_full = (cube_reg + mfw_pkg::CUBE_HALF) >> 16;
    end

    always_ff @(posedge clk)
    begin
        if (adv.lane[6])
        begin
            t3_reg       <= t3_full[mfw_pkg::T3_W-1:0];
            t2_6_reg     <= t2_5_reg;
            tq6_reg      <= tq5_reg;
            far_reg[7]   <= far_reg[6];
            outer_reg[7] <= outer_reg[6];
        end
    end

    // coefficient products, inner cubic has no linear term
    always_comb
    begin
        k3_sel  = outer_reg[7] ? coef.out_k3 : coef.in_k3;
        k2_sel  = outer_reg[7] ? coef.out_k2 : coef.in_k2;
        k1_sel  = outer_reg[7] ? coef.out_k1 : '0;
        k0_sel  = outer_reg[7] ? coef.out_k0 : coef.in_k0;
        t3_s    = $signed({1'b0, t3_reg});
        t2_s    = $signed({1'b0, t2_6_reg});
        t1_s    = $signed({1'b0, tq6_reg});
        p3_next = k3_sel * t3_s;
        p2_next = k2_sel * t2_s;
        p1_next = k1_sel * t1_s;
    end

    always_ff @(posedge clk)
    begin
        if (adv.lane[7])
        begin
            p3_reg     <= p3_next;
            p2_reg     <= p2_next;
            p1_reg     <= p1_next;
            k0s_reg    <= mfw_pkg::SUM_W'(k0_sel) <<< 16;
            far_reg[8] <= far_reg[7];
        end
    end

    // partial sums, rounding bias for the divide by six
    always_ff @(posedge clk)
    begin
        if (adv.lane[8])
        begin
            sa_reg     <= p3_reg + p2_reg;
            sb_reg     <= p1_reg + k0s_reg + mfw_pkg::SIXTH_HALF;
            far_reg[9] <= far_reg[8];
        end
    end

    // full sum, floor divide by 512
    always_comb
    begin
        sum_full = sa_reg + sb_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv.lane[9])
        begin
            q_reg       <= mfw_pkg::Q_W'(sum_full >>> mfw_pkg::QSHIFT);
            far_reg[10] <= far_reg[9];
        end
    end

    // bias to a positive value ahead of the divide by three
    always_comb
    begin
        u_next = {q_reg[mfw_pkg::Q_W-1], q_reg} + mfw_pkg::U_BIAS;
    end

    always_ff @(posedge clk)
    begin
        if (adv.lane[10])
        begin
            u_reg       <= u_next;
            far_reg[11] <= far_reg[10];
        end
    end

    // split into halves: u/3 = hi*(2^18-1)/3 + (hi+lo)/3
    always_comb
    begin
        u_hi = u_reg[mfw_pkg::U_W-1:mfw_pkg::HALF_W];
        u_lo = u_reg[mfw_pkg::HALF_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (adv.lane[11])
        begin
            hm11_reg    <= mfw_pkg::HM_W'(u_hi) * mfw_pkg::HM_W'(mfw_pkg::DIV3_HI_MULT);
            s3_reg      <= mfw_pkg::S3_W'(u_hi) + mfw_pkg::S3_W'(u_lo);
            far_reg[12] <= far_reg[11];
        end
    end

    // reciprocal multiply for the small remainder part
    always_ff @(posedge clk)
    begin
        if (adv.lane[12])
        begin
            sm_reg      <= mfw_pkg::SM_W'(s3_reg) * mfw_pkg::SM_W'(mfw_pkg::DIV3_RECIP);
            hm12_reg    <= hm11_reg;
            far_reg[13] <= far_reg[12];
        end
    end

    // recombine and drop the bias, zero beyond two
    always_comb
    begin
        quot   = mfw_pkg::QT_W'(sm_reg >> mfw_pkg::DIV3_SHIFT);
        w_full = mfw_pkg::U_W'(hm12_reg) + mfw_pkg::U_W'(quot) - mfw_pkg::U_BIAS_THIRD;
    end

    always_ff @(posedge clk)
    begin
        if (adv.lane[13])
        begin
            aw_reg <= far_reg[13] ? '0 : $signed(w_full[mfw_pkg::AW_W-1:0]);
        end
    end

    assign axis_weight = aw_reg;

endmodule

// File: rtl/mfw_merge.sv
// mfw_merge: multiplies the two axis weights, rounds to Q22, saturates
// depends on mfw_pkg; fed by two mfw_axis_lane instances
module mfw_merge (
    input  logic                              clk,
    input  mfw_pkg::mfw_adv_t                 adv,
    input  logic signed [mfw_pkg::AW_W-1:0]   wx,
    input  logic signed [mfw_pkg::AW_W-1:0]   wy,
    output logic signed [mfw_pkg::WOUT_W-1:0] weight
);

    logic signed [mfw_pkg::WP_W-1:0]   prod_next;
    logic signed [mfw_pkg::WP_W-1:0]   prod_reg;
    logic signed [mfw_pkg::WP_W-1:0]   rnd;
    logic signed [mfw_pkg::WOUT_W-1:0] weight_next;
    logic signed [mfw_pkg::WOUT_W-1:0] weight_reg;

    // axis product
    always_comb
    begin
        prod_next = wx * wy;
    end

    always_ff @(posedge clk)
    begin
        if (adv.merge[0])
        begin
            prod_reg <= prod_next;
        end
    end

    // round half up and clamp
    always_comb
    begin
        rnd = (prod_reg + mfw_pkg::W_ROUND) >>> mfw_pkg::WSHIFT;
        if (rnd > mfw_pkg::W_MAX)
        begin
            weight_next = mfw_pkg::W_MAX[mfw_pkg::WOUT_W-1:0];
        end
        else if (rnd < mfw_pkg::W_MIN)
        begin
            weight_next = mfw_pkg::W_MIN[mfw_pkg::WOUT_W-1:0];
        end
        else
        begin
            weight_next = rnd[mfw_pkg::WOUT_W-1:0];
        end
    end

    // output register
    always_ff @(posedge clk)
    begin
        if (adv.merge[1])
        begin
            weight_reg <= weight_next;
        end
    end

    assign weight = weight_reg;

endmodule

// File: rtl/mitchell_filter_weight_unit.sv
// mitchell_filter_weight_unit: one request per cycle sustained while the output does not stall:
// x and y lanes run in parallel 14-stage pipelines, the merge stages multiply (one 32x32 product)
// and saturate.
// bubbles are squeezed out when the output stalls; input stalls only when all stages hold data.
// reset (rst_n low, asynchronous) empties the pipeline and restores the registers:
// B = C = 5461, both inverse radii 8192
module mitchell_filter_weight_unit (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_write_en,
    input  logic [mfw_pkg::IDX_W-1:0]         cfg_index,
    input  logic [mfw_pkg::CFG_W-1:0]         cfg_data,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic signed [mfw_pkg::OFF_W-1:0]  offset_x,
    input  logic signed [mfw_pkg::OFF_W-1:0]  offset_y,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic signed [mfw_pkg::WOUT_W-1:0] weight
);

    localparam int N = mfw_pkg::PIPE_STAGES;

    logic signed [mfw_pkg::CFG_W-1:0] blur_b_reg;
    logic signed [mfw_pkg::CFG_W-1:0] ring_c_reg;
    logic [mfw_pkg::CFG_W-1:0]        inv_radius_x_reg;
    logic [mfw_pkg::CFG_W-1:0]        inv_radius_y_reg;
    logic [N-1:0]                     valid_reg;
    logic [N-1:0]                     en;
    logic                             out_free;
    mfw_pkg::mfw_adv_t                adv;
    mfw_pkg::mfw_coef_t               coef;
    logic signed [mfw_pkg::AW_W-1:0]  wx;
    logic signed [mfw_pkg::AW_W-1:0]  wy;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            blur_b_reg       <= mfw_pkg::BLUR_B_RESET;
            ring_c_reg       <= mfw_pkg::RING_C_RESET;
            inv_radius_x_reg <= mfw_pkg::INV_RADIUS_RESET;
            inv_radius_y_reg <= mfw_pkg::INV_RADIUS_RESET;
        end
        else if (cfg_write_en)
        begin
            unique case (cfg_index)
                mfw_pkg::CFG_BLUR_B:       blur_b_reg       <= $signed(cfg_data);
                mfw_pkg::CFG_RING_C:       ring_c_reg       <= $signed(cfg_data);
                mfw_pkg::CFG_INV_RADIUS_X: inv_radius_x_reg <= cfg_data;
                mfw_pkg::CFG_INV_RADIUS_Y: inv_radius_y_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // stage advance: a stage moves if the output drains or a hole lies at it or downstream
    always_comb
    begin
        logic hole;
        out_free = !valid_reg[N-1] || !out_stall;
        for (int i = 0; i < N; i++)
        begin
            hole = 1'b0;
            for (int j = i; j < N; j++)
            begin
                hole = hole | !valid_reg[j];
            end
            en[i] = out_free || hole;
        end
    end

    assign adv.lane  = en[mfw_pkg::LANE_STAGES-1:0];
    assign adv.merge = en[N-1:mfw_pkg::LANE_STAGES];
    assign in_stall  = !en[0];
    assign out_valid = valid_reg[N-1];

    // valid bits along the pipeline
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                valid_reg[0] <= in_valid;
            end
            for (int i = 1; i < N; i++)
            begin
                if (en[i])
                begin
                    valid_reg[i] <= valid_reg[i-1];
                end
            end
        end
    end

    // shared coefficients
    mfw_coef u_coef (
        .clk    (clk),
        .blur_b (blur_b_reg),
        .ring_c (ring_c_reg),
        .coef   (coef)
    );

    // horizontal lane
    mfw_axis_lane u_lane_x (
        .clk         (clk),
        .adv         (adv),
        .offset      (offset_x),
        .inv_radius  (inv_radius_x_reg),
        .coef        (coef),
        .axis_weight (wx)
    );

    // vertical lane
    mfw_axis_lane u_lane_y (
        .clk         (clk),
        .adv         (adv),
        .offset      (offset_y),
        .inv_radius  (inv_radius_y_reg),
        .coef        (coef),
        .axis_weight (wy)
    );

    // product and output register
    mfw_merge u_merge (
        .clk    (clk),
        .adv    (adv),
        .wx     (wx),
        .wy     (wy),
        .weight (weight)
    );

endmodule

// File: rtl/mfw_checker.sv
// mfw_checker: port-level assertions for mitchell_filter_weight_unit
// depends on mfw_pkg; bound to the top level at the end of this file
module mfw_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              in_valid,
    input logic                              in_stall,
    input logic                              out_valid,
    input logic                              out_stall,
    input logic signed [mfw_pkg::WOUT_W-1:0] weight
);

    localparam int N = mfw_pkg::PIPE_STAGES;

    logic [N-1:0] acc_hist_reg;
    logic [N-1:0] free_hist_reg;

    // request and output-free history
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_hist_reg  <= '0;
            free_hist_reg <= '0;
        end
        else
        begin
            acc_hist_reg  <= {acc_hist_reg[N-2:0], in_valid && !in_stall};
            free_hist_reg <= {free_hist_reg[N-2:0], !out_stall};
        end
    end

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(weight))
        else $error("stalled result changed or vanished");

    // with no result waiting the block never stalls its input
    a_no_false_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> !in_stall)
        else $error("input stalled while output empty");

    // a request flows through in fixed latency when the output never stalls
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        acc_hist_reg[N-1] && (&free_hist_reg[N-2:0]) |-> out_valid)
        else $error("result missing after pipeline latency");

    // nothing comes out of an empty pipeline straight after reset
    a_reset_empty: assert property (@(posedge clk)
        !rst_n |=> !out_valid)
        else $error("result shown right after reset");

endmodule

bind mitchell_filter_weight_unit mfw_checker u_mfw_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .weight    (weight)
);
